[rtl/assert_macros.svh]
// Assertion macros shared by the keyed record table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define KRT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("keyed record table assertion failed");
// Property that must hold in the cycle after the trigger.
`define KRT_ASSERT_NEXT(label, trig, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error("keyed record table assertion failed");
`else
`define KRT_ASSERT(label, prop)
`define KRT_ASSERT_NEXT(label, trig, prop)
`endif
`endif

[rtl/krt_pkg.sv]
// Types, codes and command structures of the keyed record table.
package krt_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_LOOKUP = 3'd1,
      OP_UPDATE = 3'd2,
      OP_DELETE = 3'd3,
      OP_LIST   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_DUP       = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // Where the record of a result comes from.
   typedef enum logic [2:0] {
      SRC_FAIL,
      SRC_EMPTY,
      SRC_RD,
      SRC_REQ,
      SRC_UPD
   } src_type;

   // What the record memory is written with.
   typedef enum logic [1:0] {
      WR_INSERT,
      WR_UPDATE,
      WR_SHIFT
   } wsel_type;

   typedef struct packed {
      logic [63:0]        key_low;
      logic [15:0]        key_high;
      logic [63:0]        brand0;
      logic [63:0]        brand1;
      logic [31:0]        brand2;
      logic signed [31:0] price;
   } record_type;

   localparam int RECORD_W = $bits(record_type);

   typedef struct packed {
      logic       take;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_en;
      logic       rd_next;
      logic       wr_en;
      wsel_type   wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       out_load;
      src_type    out_src;
      status_type out_status;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic   req_fire;
      op_type op;
      logic   cnt_zero;
      logic   cnt_full;
      logic   key_match;
      logic   idx_last;
      logic   out_free;
   } sts_type;

endpackage

[rtl/krt_if.sv]
// Request and response channel interfaces of the keyed record table.
interface krt_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic [63:0]        key_low;
   logic [15:0]        key_high;
   logic [63:0]        brand_word0;
   logic [63:0]        brand_word1;
   logic [31:0]        brand_word2;
   logic signed [31:0] price_in;

   modport source (
      output valid, op, key_low, key_high, brand_word0, brand_word1, brand_word2,
             price_in,
      input  ready
   );
   modport sink (
      input  valid, op, key_low, key_high, brand_word0, brand_word1, brand_word2,
             price_in,
      output ready
   );
endinterface

interface krt_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [63:0]        out_key_low;
   logic [15:0]        out_key_high;
   logic [63:0]        out_brand0;
   logic [63:0]        out_brand1;
   logic [31:0]        out_brand2;
   logic signed [31:0] out_price;
   logic               last;

   modport source (
      output valid, status, out_key_low, out_key_high, out_brand0, out_brand1,
             out_brand2, out_price, last,
      input  ready
   );
   modport sink (
      input  valid, status, out_key_low, out_key_high, out_brand0, out_brand1,
             out_brand2, out_price, last,
      output ready
   );
endinterface

[rtl/krt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module krt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/krt_ctrl.sv]
// Controller state machine that sequences each table request.
module krt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  krt_pkg::sts_type sts,
   output krt_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_EMIT,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_LIST_RD,
      S_LIST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   krt_pkg::status_type st_ff, st_in;

   always_comb begin
      cmd        = '0;
      cmd.wr_sel = krt_pkg::WR_SHIFT;
      cmd.out_src = krt_pkg::SRC_RD;
      cmd.out_status = krt_pkg::ST_OK;
      state_in   = state_ff;
      st_in      = st_ff;

      unique case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (sts.req_fire) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.idx_clr = 1'b1;
            unique case (sts.op) inside
               krt_pkg::OP_INSERT: begin
                  if (sts.cnt_full) begin
                     st_in    = krt_pkg::ST_FULL;
                     state_in = S_EMIT;
                  end else if (sts.cnt_zero) begin
                     st_in    = krt_pkg::ST_OK;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end
               krt_pkg::OP_LOOKUP, krt_pkg::OP_UPDATE, krt_pkg::OP_DELETE: begin
                  if (sts.cnt_zero) begin
                     st_in    = krt_pkg::ST_NOT_FOUND;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end
               krt_pkg::OP_LIST: begin
                  if (sts.cnt_zero) begin
                     st_in    = krt_pkg::ST_EMPTY;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_LIST_RD;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SRCH_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (sts.key_match) begin
               st_in    = (sts.op == krt_pkg::OP_INSERT) ? krt_pkg::ST_DUP : krt_pkg::ST_OK;
               state_in = S_EMIT;
            end else if (sts.idx_last) begin
               st_in    = (sts.op == krt_pkg::OP_INSERT) ? krt_pkg::ST_OK
                                                         : krt_pkg::ST_NOT_FOUND;
               state_in = S_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = st_ff;
               cmd.out_last   = 1'b1;
               state_in       = S_IDLE;
               if (st_ff != krt_pkg::ST_OK) begin
                  cmd.out_src = (st_ff == krt_pkg::ST_EMPTY) ? krt_pkg::SRC_EMPTY
                                                             : krt_pkg::SRC_FAIL;
               end else begin
                  unique case (sts.op)
                     krt_pkg::OP_INSERT: begin
                        cmd.out_src = krt_pkg::SRC_REQ;
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = krt_pkg::WR_INSERT;
                        cmd.cnt_inc = 1'b1;
                     end
                     krt_pkg::OP_UPDATE: begin
                        cmd.out_src = krt_pkg::SRC_UPD;
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = krt_pkg::WR_UPDATE;
                     end
                     krt_pkg::OP_DELETE: begin
                        cmd.out_src = krt_pkg::SRC_RD;
                        state_in    = S_SHIFT_RD;
                     end
                     default: begin
                        cmd.out_src = krt_pkg::SRC_RD;
                     end
                  endcase
               end
            end
         end
         S_SHIFT_RD: begin
            if (sts.idx_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = krt_pkg::WR_SHIFT;
            cmd.idx_inc = 1'b1;
            state_in    = S_SHIFT_RD;
         end
         S_LIST_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_LIST_EMIT;
         end
         S_LIST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = krt_pkg::SRC_RD;
               cmd.out_last = sts.idx_last;
               if (sts.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_LIST_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= krt_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

endmodule

[rtl/krt_dp.sv]
// Datapath: request registers, record memory, scan index, fill count and result register.
module krt_dp #(
   parameter int CAPACITY = krt_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   krt_req_if.sink          req_bus,
   krt_rsp_if.source        rsp_bus,
   input  krt_pkg::cmd_type cmd,
   output krt_pkg::sts_type sts
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                    fire;
   logic [2:0]              op_ff, op_in;
   krt_pkg::record_type     req_rec_ff, req_rec_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    out_valid_ff, out_valid_in;
   krt_pkg::record_type     out_rec_ff, out_rec_in;
   krt_pkg::status_type     out_status_ff, out_status_in;
   logic                    out_last_ff, out_last_in;

   logic [CNT_W-1:0]        idx_plus;
   logic [CNT_W-1:0]        rd_idx;
   logic [IDX_W-1:0]        rd_addr;
   logic [IDX_W-1:0]        wr_addr;
   krt_pkg::record_type     wr_rec;
   logic [krt_pkg::RECORD_W-1:0] wr_data;
   logic [krt_pkg::RECORD_W-1:0] rd_data;
   krt_pkg::record_type     rd_rec;
   krt_pkg::record_type     upd_rec;
   krt_pkg::record_type     sel_rec;

   assign fire          = req_bus.valid && cmd.take;
   assign req_bus.ready = cmd.take;

   always_comb begin
      op_in      = op_ff;
      req_rec_in = req_rec_ff;
      if (fire) begin
         op_in               = req_bus.op;
         req_rec_in.key_low  = req_bus.key_low;
         req_rec_in.key_high = req_bus.key_high;
         req_rec_in.brand0   = req_bus.brand_word0;
         req_rec_in.brand1   = req_bus.brand_word1;
         req_rec_in.brand2   = req_bus.brand_word2;
         req_rec_in.price    = req_bus.price_in;
      end
   end

   // Record memory addressing.
   assign idx_plus = idx_ff + CNT_W'(1);
   assign rd_idx   = cmd.rd_next ? idx_plus : idx_ff;
   assign rd_addr  = rd_idx[IDX_W-1:0];
   assign rd_rec   = rd_data;

   always_comb begin
      upd_rec       = rd_rec;
      upd_rec.price = req_rec_ff.price;
   end

   always_comb begin
      case (cmd.wr_sel)
         krt_pkg::WR_INSERT: begin
            wr_addr = count_ff[IDX_W-1:0];
            wr_rec  = req_rec_ff;
         end
         krt_pkg::WR_UPDATE: begin
            wr_addr = idx_ff[IDX_W-1:0];
            wr_rec  = upd_rec;
         end
         default: begin
            wr_addr = idx_ff[IDX_W-1:0];
            wr_rec  = rd_rec;
         end
      endcase
   end

   assign wr_data = wr_rec;

   krt_ram #(
      .WIDTH (krt_pkg::RECORD_W),
      .DEPTH (CAPACITY)
   ) u_records (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_plus;
      end
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Result record selection.
   always_comb begin
      sel_rec = '0;
      case (cmd.out_src)
         krt_pkg::SRC_FAIL: begin
            sel_rec.key_low  = req_rec_ff.key_low;
            sel_rec.key_high = req_rec_ff.key_high;
         end
         krt_pkg::SRC_RD:  sel_rec = rd_rec;
         krt_pkg::SRC_REQ: sel_rec = req_rec_ff;
         krt_pkg::SRC_UPD: sel_rec = upd_rec;
         default:          sel_rec = '0;
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_rec_in    = out_rec_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      if (cmd.out_load) begin
         out_valid_in  = 1'b1;
         out_rec_in    = sel_rec;
         out_status_in = cmd.out_status;
         out_last_in   = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff         <= op_in;
      req_rec_ff    <= req_rec_in;
      out_rec_ff    <= out_rec_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign sts.req_fire  = fire;
   assign sts.op        = krt_pkg::op_type'(op_ff);
   assign sts.cnt_zero  = (count_ff == '0);
   assign sts.cnt_full  = (count_ff == CNT_W'(CAPACITY));
   assign sts.key_match = (rd_rec.key_low == req_rec_ff.key_low) &&
                          (rd_rec.key_high == req_rec_ff.key_high);
   assign sts.idx_last  = (idx_plus == count_ff);
   assign sts.out_free  = !out_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.out_key_low  = out_rec_ff.key_low;
   assign rsp_bus.out_key_high = out_rec_ff.key_high;
   assign rsp_bus.out_brand0   = out_rec_ff.brand0;
   assign rsp_bus.out_brand1   = out_rec_ff.brand1;
   assign rsp_bus.out_brand2   = out_rec_ff.brand2;
   assign rsp_bus.out_price    = out_rec_ff.price;
   assign rsp_bus.last         = out_last_ff;

endmodule

[rtl/keyed_record_table.sv]
// Top level of the keyed record table: controller, datapath and checks.
//
// Channel   Direction  Handshake      Carries
// req_bus   in         valid/ready    op, key, brand text and price of one request
// rsp_bus   out        valid/ready    status, record fields and last flag of one result
//
// A request transaction is taken only while the controller is idle; it then passes
// through dispatch and, for each record it compares, a read state and a compare state,
// because every step waits on the registered read of the single record memory. A
// delete then moves each later record down one place with a shift read and a shift
// write; a list reads and then emits each record in turn.
// Reset is synchronous and clears the fill count, the scan index, the response valid
// flag and the control state only; the memory is never read at or above the fill
// count, so it needs no clearing pass.
// A stalled response holds in the output register and the controller waits for it.
`include "assert_macros.svh"

module keyed_record_table #(
   parameter int CAPACITY = krt_pkg::CAPACITY_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   krt_req_if.sink   req_bus,
   krt_rsp_if.source rsp_bus
);

   // Commands from the controller to the datapath, and status back.
   krt_pkg::cmd_type cmd;
   krt_pkg::sts_type sts;

   // The controller walks each request through search, list, result and shift phases.
   krt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // The datapath holds the records, the fill count and the response register.
   krt_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .sts     (sts)
   );

   // A result is never written over one that has not yet been taken.
   `KRT_ASSERT(a_load_only_when_free, cmd.out_load |-> sts.out_free)
   // The table grows only by an insert write, and never beyond its capacity.
   `KRT_ASSERT(a_grow_by_insert, cmd.cnt_inc |-> (cmd.wr_en && !sts.cnt_full))
   // A delete only ever shrinks a table that holds at least one record.
   `KRT_ASSERT(a_shrink_nonempty, cmd.cnt_dec |-> !sts.cnt_zero)
   // Once a request is taken, no further request is taken until it has been worked off.
   `KRT_ASSERT_NEXT(a_one_request, sts.req_fire, !req_bus.ready)

endmodule
